// ----- sv/sjfq_pkg.sv -----
// Package: shared types and constants for the shortest-job-first queue.
`timescale 1ns / 1ps

package sjfq_pkg;

  // Table geometry
  localparam int unsigned SLOTS  = 16;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  // Field widths
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned OWNER_W = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned OCC_W   = 5;

  // Stream word widths
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 64;

  // Action codes carried in the input tuser bit
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // One stored job
  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic               sticky;
    logic [OWNER_W-1:0] owner;
    logic [SIZE_W-1:0]  size;
  } slot_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_e;

endpackage

// ----- sv/shortest_job_first_queue_unit.sv -----
// Top level: shortest-job-first job table with a one-slot-per-cycle scanner.
`timescale 1ns / 1ps
//
// Channel   Dir  Handshake                  Contents
// s_axis    in   s_axis_tvalid/tready       tuser=action, tlast=end_marker, tdata=job
// m_axis    out  m_axis_tvalid/tready       tuser=ok, tlast=out_end_marker, tdata=result
//
// Insert walks the slots from index 0, one per cycle, and stops at the first free one
// (or at the last slot when the table is full).
// Remove walks all SLOTS entries through the registered table read and one size
// comparator before the result is loaded.
// Reset empties the table at once (per-slot used bits); no clearing pass.
// A finished result sits in the output register; the next word is taken meanwhile,
// and a later result waits in the final state until the output register is free.

module shortest_job_first_queue_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tdata: job_size[15:0], submitter[23:16], now[55:24]
  input  logic [sjfq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: action (0 insert, 1 remove)
  input  logic                               s_axis_tuser,
  // tlast: end_marker
  input  logic                               s_axis_tlast,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: out_size[15:0], out_submitter[23:16], out_time[55:24],
  //        occupancy[60:56], zero[63:61]
  output logic [sjfq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: ok
  output logic                               m_axis_tuser,
  // tlast: out_end_marker
  output logic                               m_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready
);

  import sjfq_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // State
  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q;
  logic [SLOTS-1:0]  used_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              act_q;
  slot_t             job_q;

  // Scan and compare
  slot_t             mem_q [SLOTS];
  slot_t             rd_q;
  logic [IDX_W-1:0]  cmp_idx_q;
  logic              cmp_vld_q;
  slot_t             best_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic              found_q;
  logic              better;

  // Output register
  logic                   out_valid_q;
  logic [OUT_DATA_W-1:0]  out_data_q;
  logic                   out_ok_q;
  logic                   out_end_q;

  // Control
  logic in_fire, out_fire;
  logic mem_we, load_out, commit_free;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Comparator: used slot with strictly smaller size wins, earlier index keeps ties
  assign better = cmp_vld_q && used_q[cmp_idx_q]
                  && (!found_q || (rd_q.size < best_q.size));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (act_q == ACT_INSERT) begin
          if (!used_q[idx_q] || idx_q == LAST_IDX) state_d = ST_DONE;
        end else if (idx_q == LAST_IDX) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    load_out      = 1'b0;
    commit_free   = 1'b0;
    count_d       = count_q;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_SCAN: begin
        if (act_q == ACT_INSERT && !used_q[idx_q]) begin
          mem_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      ST_DONE: begin
        load_out = !out_valid_q || m_axis_tready;
        if (act_q == ACT_REMOVE && found_q && !best_q.sticky) begin
          commit_free = load_out;
          count_d     = count_q - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      used_q      <= '0;
      count_q     <= '0;
      act_q       <= ACT_INSERT;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == ST_SCAN) && (act_q == ACT_REMOVE);
      if (in_fire) begin
        act_q   <= s_axis_tuser;
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (state_q == ST_SCAN && idx_q != LAST_IDX) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (mem_we) begin
        used_q[idx_q] <= 1'b1;
        found_q       <= 1'b1;
      end
      if (better) found_q <= 1'b1;
      if (commit_free) used_q[best_idx_q] <= 1'b0;
      if (mem_we || commit_free) count_q <= count_d;
      if (load_out)      out_valid_q <= 1'b1;
      else if (out_fire) out_valid_q <= 1'b0;
    end
  end

  // Job table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[idx_q] <= job_q;
    rd_q <= mem_q[idx_q];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      job_q.size   <= s_axis_tdata[SIZE_W-1:0];
      job_q.owner  <= s_axis_tdata[SIZE_W +: OWNER_W];
      job_q.stamp  <= s_axis_tdata[SIZE_W+OWNER_W +: TIME_W];
      job_q.sticky <= s_axis_tlast;
    end
    cmp_idx_q <= idx_q;
    if (better) begin
      best_q     <= rd_q;
      best_idx_q <= cmp_idx_q;
    end
    if (load_out) begin
      out_ok_q <= found_q;
      if (act_q == ACT_REMOVE && found_q) begin
        out_end_q  <= best_q.sticky;
        out_data_q <= {3'b000, OCC_W'(count_d), best_q.stamp, best_q.owner, best_q.size};
      end else begin
        out_end_q  <= 1'b0;
        out_data_q <= {3'b000, OCC_W'(count_d), {(TIME_W+OWNER_W+SIZE_W){1'b0}}};
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tlast  = out_end_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(SLOTS))
    else $error("job count exceeds table size");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == int'(count_q))
    else $error("job count out of step with used slots");

  a_best_is_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && act_q == ACT_REMOVE && found_q) |-> used_q[best_idx_q])
    else $error("selected job sits in a free slot");

  a_insert_free_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (used_q[$past(idx_q)] && count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not claim its slot");

endmodule
